FILE: rtl/prcc_pkg.sv
// prcc_pkg: shared types and constants of the ratio-cut cost unit
// used by the controller, the datapath and the top level; no dependencies

package prcc_pkg;

	// sizes
	localparam int MAX_NODES  = 4096;
	localparam int MAX_PARTS  = 16;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int LABEL_W    = 4;
	localparam int PART_IDX_W = $clog2(MAX_PARTS);
	localparam int PCNT_W     = 5;
	localparam int WEIGHT_W   = 13;
	localparam int CUT_W      = 18;
	localparam int FRAC_W     = 16;
	localparam int TERM_W     = CUT_W + FRAC_W;
	localparam int SUM_W      = TERM_W + PART_IDX_W;
	localparam int COST_W     = 40;
	localparam int DIV_STEPS  = SUM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// counter limits and register defaults
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = '1;
	localparam logic [CUT_W-1:0]    CUT_MAX      = '1;
	localparam logic [PCNT_W-1:0]   PART_MIN     = PCNT_W'(2);
	localparam logic [PCNT_W-1:0]   PART_LIMIT   = PCNT_W'(MAX_PARTS);
	localparam logic [PCNT_W-1:0]   PART_DEFAULT = PCNT_W'(2);

	// request opcodes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_EDGE   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// request payload
	typedef struct packed {
		logic [1:0]        op;
		logic [NODE_W-1:0] node_index;
		logic [LABEL_W-1:0] partition;
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
	} req_t;

	// result payload
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              empty_partition;
		logic              label_error;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic cap;
		logic fin_clr;
		logic lbl_wr;
		logic edge_rd;
		logic cut_a;
		logic cut_b;
		logic div_load_term;
		logic div_load_final;
		logic div_step;
		logic term_add;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_last;
		logic idx_last;
	} status_t;

endpackage

FILE: rtl/partition_ratio_cut_cost_unit.sv
// partition_ratio_cut_cost_unit: top level of the scaled ratio-cut cost unit
// depends on prcc_pkg, prcc_ctrl, prcc_datapath (and prcc_ram below it)
//
// Usage:
//  A request (req) is taken at a clock edge with start high and busy low.
//  op load writes the node's partition into the label store and bumps that
//  partition's weight; op edge reads both endpoint labels and bumps the cut
//  count of each partition when they differ; op finish returns the cost.
//  Only a finish produces a result: it appears on result with done high for one
//  cycle, and the receiver cannot stall it.
//  After the accepting edge: load writes the label store and the weight;
//   edge reads both labels, then bumps each endpoint's cut count in turn;
//   an unused op returns to idle; finish sweeps all 16 partition slots,
//   each with a divider load, divider steps and an accumulate, then divides
//   the sum by partitions minus one (load, steps) and emits; done rises
//   with busy already low.
//  The 38-step bit-serial divider, shared by every term and the final
//  division, sets the finish time; the label RAM's registered read sets edge.
//  part_count is written over cfg_valid/cfg_ready/cfg_data; the user must write
//  it only while idle, a rule the block leaves to the user; cfg_ready is always high.
//  Reset clears the counters, the error flag and sets part_count to 2; the
//  label store holds no defined value until written.

module partition_ratio_cut_cost_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  prcc_pkg::req_t              req,
	output prcc_pkg::result_t           result,
	output logic                        done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [prcc_pkg::PCNT_W-1:0] cfg_data
);
	import prcc_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	prcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.op),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage and arithmetic
	prcc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.result   (result),
		.done     (done)
	);

	// result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");

	// the unit is free again when the result shows
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("busy while result is presented");

	// an accepted finish keeps the unit busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.op == OP_FINISH)) |=> (busy && !done))
		else $error("finish request did not start the sweep");

	// only the finish sweep emits, never a load or edge
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((req.op == OP_LOAD) || (req.op == OP_EDGE))) |=> ##1 !done)
		else $error("result emitted for a load or edge request");

endmodule

FILE: rtl/prcc_ram.sv
// prcc_ram: generic RAM, one write port and two registered read ports
// no package dependencies

module prcc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered reads, read data holds while idle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

FILE: rtl/prcc_ctrl.sv
// prcc_ctrl: sequencer of the ratio-cut cost unit
// depends on prcc_pkg for request opcodes and the command/status structs

module prcc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  prcc_pkg::status_t  status,
	output logic               busy,
	output prcc_pkg::cmd_t     cmd
);
	import prcc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EDGE_RD,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_FIN_LOAD,
		ST_FIN_DIV,
		ST_FIN_ACC,
		ST_FINAL_LOAD,
		ST_FINAL_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   accept;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					case (op)
						OP_LOAD: state_d = ST_LOAD;
						OP_EDGE: state_d = ST_EDGE_RD;
						OP_FINISH: begin
							cmd.fin_clr = 1'b1;
							state_d     = ST_FIN_LOAD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.lbl_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_EDGE_RD: begin
				cmd.edge_rd = 1'b1;
				state_d     = ST_EDGE_A;
			end
			ST_EDGE_A: begin
				cmd.cut_a = 1'b1;
				state_d   = ST_EDGE_B;
			end
			ST_EDGE_B: begin
				cmd.cut_b = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_FIN_LOAD: begin
				cmd.div_load_term = 1'b1;
				state_d           = ST_FIN_DIV;
			end
			ST_FIN_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FIN_ACC;
				end
			end
			ST_FIN_ACC: begin
				cmd.term_add = 1'b1;
				state_d      = status.idx_last ? ST_FINAL_LOAD : ST_FIN_LOAD;
			end
			ST_FINAL_LOAD: begin
				cmd.div_load_final = 1'b1;
				state_d            = ST_FINAL_DIV;
			end
			ST_FINAL_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

endmodule

FILE: rtl/prcc_datapath.sv
// prcc_datapath: label store, partition counters, shared divider and result register
// depends on prcc_pkg and instantiates prcc_ram

module prcc_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  prcc_pkg::req_t            req,
	input  logic                      cfg_we,
	input  logic [prcc_pkg::PCNT_W-1:0] cfg_data,
	input  prcc_pkg::cmd_t            cmd,
	output prcc_pkg::status_t         status,
	output prcc_pkg::result_t         result,
	output logic                      done
);
	import prcc_pkg::*;

	req_t                  req_q;
	logic [PCNT_W-1:0]     part_count_q;
	logic [PCNT_W-1:0]     p_act;
	logic [LABEL_W-1:0]    lbl_a;
	logic [LABEL_W-1:0]    lbl_b;
	logic                  lbl_differ;

	logic [WEIGHT_W-1:0]   weight_q [MAX_PARTS];
	logic [CUT_W-1:0]      cut_q [MAX_PARTS];
	logic [PART_IDX_W-1:0] w_addr;
	logic [PART_IDX_W-1:0] c_addr;
	logic [WEIGHT_W-1:0]   w_rd;
	logic [CUT_W-1:0]      c_rd;
	logic                  error_q;

	logic [PART_IDX_W-1:0] idx_q;
	logic                  idx_active;
	logic [SUM_W-1:0]      sum_q;
	logic                  empty_q;

	logic [SUM_W-1:0]      quo_q;
	logic [WEIGHT_W-1:0]   rem_q;
	logic [WEIGHT_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [WEIGHT_W:0]     trial;
	logic [WEIGHT_W:0]     trial_diff;
	logic                  trial_ge;

	result_t               result_q;
	logic                  done_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req;
		end
	end

	// partition count register and its clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= PART_DEFAULT;
		end else if (cfg_we) begin
			part_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (part_count_q < PART_MIN) begin
			p_act = PART_MIN;
		end else if (part_count_q > PART_LIMIT) begin
			p_act = PART_LIMIT;
		end else begin
			p_act = part_count_q;
		end
	end

	// label store, both endpoints read in the same cycle
	prcc_ram #(
		.WIDTH(LABEL_W),
		.DEPTH(MAX_NODES)
	) u_label_ram (
		.clk       (clk),
		.wr_en     (cmd.lbl_wr),
		.wr_addr   (req_q.node_index),
		.wr_data   (req_q.partition),
		.rd_en     (cmd.edge_rd),
		.rd_addr_a (req_q.src_node),
		.rd_addr_b (req_q.dst_node),
		.rd_data_a (lbl_a),
		.rd_data_b (lbl_b)
	);

	assign lbl_differ = (lbl_a != lbl_b);

	// counter read ports, one address each
	assign w_addr = (cmd.div_load_term || cmd.term_add) ? idx_q : req_q.partition;
	assign w_rd   = weight_q[w_addr];

	always_comb begin
		if (cmd.cut_a) begin
			c_addr = lbl_a;
		end else if (cmd.cut_b) begin
			c_addr = lbl_b;
		end else begin
			c_addr = idx_q;
		end
	end
	assign c_rd = cut_q[c_addr];

	// weight and cut counters, saturating, cleared as the finish sweeps them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PARTS; i++) begin
				weight_q[i] <= '0;
				cut_q[i]    <= '0;
			end
		end else begin
			if (cmd.lbl_wr && (w_rd != WEIGHT_MAX)) begin
				weight_q[w_addr] <= w_rd + WEIGHT_W'(1);
			end else if (cmd.term_add) begin
				weight_q[w_addr] <= '0;
			end
			if ((cmd.cut_a || cmd.cut_b) && lbl_differ && (c_rd != CUT_MAX)) begin
				cut_q[c_addr] <= c_rd + CUT_W'(1);
			end else if (cmd.term_add) begin
				cut_q[c_addr] <= '0;
			end
		end
	end

	// out-of-range label flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q <= 1'b0;
		end else if (cmd.lbl_wr && ({1'b0, req_q.partition} >= p_act)) begin
			error_q <= 1'b1;
		end else if (cmd.emit) begin
			error_q <= 1'b0;
		end
	end

	// finish sweep: partition index, term sum, empty flag
	assign idx_active = ({1'b0, idx_q} < p_act);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= '0;
			empty_q <= 1'b0;
		end else if (cmd.fin_clr) begin
			idx_q   <= '0;
			sum_q   <= '0;
			empty_q <= 1'b0;
		end else if (cmd.term_add) begin
			idx_q <= idx_q + PART_IDX_W'(1);
			if (idx_active) begin
				if (w_rd == '0) begin
					empty_q <= 1'b1;
				end else begin
					sum_q <= sum_q + SUM_W'(quo_q[TERM_W-1:0]);
				end
			end
		end
	end

	assign status.idx_last = (idx_q == PART_IDX_W'(MAX_PARTS - 1));

	// shared restoring divider, one quotient bit per cycle
	assign trial      = {rem_q, quo_q[SUM_W-1]};
	assign trial_diff = trial - {1'b0, dvs_q};
	assign trial_ge   = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load_term) begin
			quo_q <= SUM_W'({c_rd, FRAC_W'(0)});
			dvs_q <= w_rd;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_load_final) begin
			quo_q <= sum_q;
			dvs_q <= WEIGHT_W'(p_act - PCNT_W'(1));
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	assign status.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// result register; the quotient stays below 2^SUM_W so the cost never saturates
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.cost            <= COST_W'(quo_q);
			result_q.empty_partition <= empty_q;
			result_q.label_error     <= error_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule
